/* design/ile_pkg.sv */
// ----------------------------------------------------------------------------
// ile_pkg: shared definitions for the indexed list engine
// Sizes, action and status codes, the RAM request and result records, and
// the capacity arithmetic used by the controller.
// ----------------------------------------------------------------------------
package ile_pkg;

    // Storage geometry.
    localparam int DEPTH  = 16;
    localparam int WIDTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 5;

    // Action codes carried on the input beat.
    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_ERASE  = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    // Status codes carried on the result beat.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One access to the entry RAM: a write and a read address.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WIDTH-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // One result beat.
    typedef struct packed {
        logic [31:0]      read_value;
        t_status          status;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] capacity;
        logic             empty;
    } t_result;

    // Clamp a capacity value to the list depth.
    function automatic logic [CNT_W-1:0] sat_depth(input logic [CNT_W:0] v);
        logic [CNT_W-1:0] r;
        if (v > (CNT_W+1)'(DEPTH)) begin
            r = CNT_W'(DEPTH);
        end else begin
            r = v[CNT_W-1:0];
        end
        return r;
    endfunction

    // Growth step: zero becomes one, anything else doubles, capped at the depth.
    function automatic logic [CNT_W-1:0] grow_cap(input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] r;
        if (cap == '0) begin
            r = CNT_W'(1);
        end else begin
            r = sat_depth({cap, 1'b0});
        end
        return r;
    endfunction

endpackage

/* design/ile_ram.sv */
// ----------------------------------------------------------------------------
// ile_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered, so it appears
// in the cycle after the address. A read of the address being written returns
// the old contents.
// ----------------------------------------------------------------------------
module ile_ram #(
    parameter int W  = 32,
    parameter int D  = 16,
    parameter int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] mem [D];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

/* design/ile_ctrl.sv */
// ----------------------------------------------------------------------------
// ile_ctrl: list sequencer
// Holds the entry count and the reported capacity, checks each action, and
// drives the entry RAM. Insert and erase move entries one at a time through
// a read-then-write pipeline; reads and writes in flight always touch
// different entries, so no forwarding is needed.
// ----------------------------------------------------------------------------
module ile_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [1:0]                 i_action,
    input  logic [4:0]                 i_position,
    input  logic [31:0]                i_element_value,
    input  logic                       i_cfg_write,
    input  logic [4:0]                 i_cfg_data,
    input  logic [ile_pkg::WIDTH-1:0]  i_ram_rdata,
    output ile_pkg::t_ram_req          o_ram_req,
    output logic                       o_idle,
    output logic                       o_res_valid,
    output ile_pkg::t_result           o_res
);
    import ile_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_FLUSH = 5'b00100,
        S_PUT   = 5'b01000,
        S_READ  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_cap, n_cap;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_rd_addr, n_rd_addr;
    logic [ADDR_W-1:0] r_end, n_end;
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;
    logic              r_up, n_up;
    logic              r_ins, n_ins;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [WIDTH-1:0]  r_val, n_val;

    logic              full;
    logic [CNT_W-1:0]  cap_after_add;
    logic [ADDR_W-1:0] pos_a;
    logic [ADDR_W-1:0] cnt_a;
    logic [ADDR_W-1:0] last_a;
    logic [ADDR_W-1:0] pos_p1;
    logic [WIDTH-1:0]  val_w;
    logic [31:0]       rd_value;
    t_status           status;

    // Decoded views of the current state and the incoming beat.
    assign full          = (r_count == CNT_W'(DEPTH));
    assign cap_after_add = (r_count >= r_cap) ? grow_cap(r_cap) : r_cap;
    assign pos_a         = i_position[ADDR_W-1:0];
    assign cnt_a         = r_count[ADDR_W-1:0];
    assign last_a        = ADDR_W'(r_count - CNT_W'(1));
    assign pos_p1        = ADDR_W'(i_position + 5'd1);
    assign val_w         = WIDTH'(i_element_value);

    // Sequencer and RAM access.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cap     = r_cap;
        n_pend    = r_pend;
        n_rd_addr = r_rd_addr;
        n_end     = r_end;
        n_wr_addr = r_wr_addr;
        n_up      = r_up;
        n_ins     = r_ins;
        n_pos     = r_pos;
        n_val     = r_val;

        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = r_wr_addr;
        o_ram_req.wdata = i_ram_rdata;
        o_ram_req.raddr = r_rd_addr;

        o_res_valid = 1'b0;
        rd_value    = '0;
        status      = ST_OK;

        case (r_state)
            S_IDLE: begin
                o_ram_req.raddr = pos_a;
                if (i_cfg_write) begin
                    // A configuration write reconstructs the list.
                    n_cap   = sat_depth({1'b0, i_cfg_data});
                    n_count = '0;
                end else if (i_accept) begin
                    n_pend = 1'b0;
                    case (t_action'(i_action))
                        ACT_APPEND: begin
                            o_res_valid = 1'b1;
                            if (full) begin
                                status = ST_FULL;
                            end else begin
                                o_ram_req.we    = 1'b1;
                                o_ram_req.waddr = cnt_a;
                                o_ram_req.wdata = val_w;
                                n_count         = r_count + CNT_W'(1);
                                n_cap           = cap_after_add;
                            end
                        end
                        ACT_INSERT: begin
                            if (i_position > r_count) begin
                                status      = ST_RANGE;
                                o_res_valid = 1'b1;
                            end else if (full) begin
                                status      = ST_FULL;
                                o_res_valid = 1'b1;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                                n_cap   = cap_after_add;
                                if (i_position == r_count) begin
                                    // Insert at the end needs no moves.
                                    o_ram_req.we    = 1'b1;
                                    o_ram_req.waddr = pos_a;
                                    o_ram_req.wdata = val_w;
                                    o_res_valid     = 1'b1;
                                end else begin
                                    // Move entries up, from the last one down.
                                    n_rd_addr = last_a;
                                    n_end     = pos_a;
                                    n_up      = 1'b0;
                                    n_ins     = 1'b1;
                                    n_pos     = pos_a;
                                    n_val     = val_w;
                                    n_state   = S_SHIFT;
                                end
                            end
                        end
                        ACT_ERASE: begin
                            if (i_position >= r_count) begin
                                status      = ST_RANGE;
                                o_res_valid = 1'b1;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                                if (pos_a == last_a) begin
                                    // Erasing the last entry needs no moves.
                                    o_res_valid = 1'b1;
                                end else begin
                                    // Move entries down, from the one after
                                    // the hole to the last one.
                                    n_rd_addr = pos_p1;
                                    n_end     = last_a;
                                    n_up      = 1'b1;
                                    n_ins     = 1'b0;
                                    n_state   = S_SHIFT;
                                end
                            end
                        end
                        ACT_READ: begin
                            if (i_position >= r_count) begin
                                status      = ST_RANGE;
                                o_res_valid = 1'b1;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // Write back the entry read last cycle while reading the next.
                o_ram_req.we = r_pend;
                n_pend       = 1'b1;
                n_wr_addr    = r_up ? (r_rd_addr - ADDR_W'(1)) : (r_rd_addr + ADDR_W'(1));
                if (r_rd_addr == r_end) begin
                    n_state = S_FLUSH;
                end else begin
                    n_rd_addr = r_up ? (r_rd_addr + ADDR_W'(1)) : (r_rd_addr - ADDR_W'(1));
                end
            end
            S_FLUSH: begin
                // Last moved entry goes back into the RAM.
                o_ram_req.we = 1'b1;
                if (r_ins) begin
                    n_state = S_PUT;
                end else begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_PUT: begin
                // The new word fills the opened slot.
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_pos;
                o_ram_req.wdata = r_val;
                o_res_valid     = 1'b1;
                n_state         = S_IDLE;
            end
            S_READ: begin
                rd_value    = 32'(i_ram_rdata);
                o_res_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result fields show the state after the action.
    assign o_res.read_value = rd_value;
    assign o_res.status     = status;
    assign o_res.count      = n_count;
    assign o_res.capacity   = n_cap;
    assign o_res.empty      = (n_count == '0);
    assign o_idle           = (r_state == S_IDLE);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cap   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cap   <= n_cap;
            r_pend  <= n_pend;
        end
    end

    // Move bookkeeping.
    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_end     <= n_end;
        r_wr_addr <= n_wr_addr;
        r_up      <= n_up;
        r_ins     <= n_ins;
        r_pos     <= n_pos;
        r_val     <= n_val;
    end

endmodule

/* design/indexed_list_engine.sv */
// Throughput: one item at a time; the next beat is taken only after the result beat has
// left the output register. Moves go one entry per cycle.
// Reset: count and capacity clear to zero; entry contents are not cleared.
// A configuration write sets the capacity and empties the list.
// ----------------------------------------------------------------------------
// indexed_list_engine: bounded ordered list of words
// Top level: entry RAM, sequencer and the result output register.
// ----------------------------------------------------------------------------
module indexed_list_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [4:0]  i_position,
    input  logic [31:0] i_element_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_read_value,
    output logic [1:0]  o_status,
    output logic [4:0]  o_count,
    output logic [4:0]  o_capacity_now,
    output logic        o_empty_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);
    import ile_pkg::*;

    t_ram_req         w_ram_req;
    logic [WIDTH-1:0] w_ram_rdata;
    logic             w_idle;
    logic             w_res_valid;
    t_result          w_res;
    logic             w_in_accept;
    logic             w_cfg_write;
    logic             r_out_valid;
    t_result          r_out;

    // Handshakes: a new beat is taken only with the sequencer idle, the output
    // register free and no configuration write on offer. A configuration
    // write is taken only while the sequencer is idle.
    assign o_stall     = !(w_idle && !r_out_valid) || i_cfg_valid;
    assign w_in_accept = i_valid && !o_stall;
    assign o_cfg_ready = w_idle;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    // Entry storage.
    ile_ram #(
        .W (WIDTH),
        .D (DEPTH),
        .AW(ADDR_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_req.we),
        .i_waddr(w_ram_req.waddr),
        .i_wdata(w_ram_req.wdata),
        .i_raddr(w_ram_req.raddr),
        .o_rdata(w_ram_rdata)
    );

    // Sequencer.
    ile_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_in_accept),
        .i_action       (i_action),
        .i_position     (i_position),
        .i_element_value(i_element_value),
        .i_cfg_write    (w_cfg_write),
        .i_cfg_data     (i_cfg_data),
        .i_ram_rdata    (w_ram_rdata),
        .o_ram_req      (w_ram_req),
        .o_idle         (w_idle),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res)
    );

    // Output register: holds a result beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_read_value   = r_out.read_value;
    assign o_status       = r_out.status;
    assign o_count        = r_out.count;
    assign o_capacity_now = r_out.capacity;
    assign o_empty_res    = r_out.empty;

    // A result never lands on an occupied output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> !r_out_valid)
        else $error("result produced while output register full");

    // After an accepted beat the block stalls in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_stall)
        else $error("input accepted again before previous result");

    // The count never passes the reported capacity or the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count <= o_capacity_now) && (o_capacity_now <= CNT_W'(DEPTH))
                    && (o_empty_res == (o_count == '0)))
        else $error("count or capacity out of bounds");

endmodule

/* sim/ile_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ile_checker: result checker for the indexed list engine
// Watches the input, result and configuration channels, keeps its own copy
// of the list, predicts one result beat per accepted input beat and compares
// every accepted result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ile_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_action,
    input  logic [4:0]  i_position,
    input  logic [31:0] i_element_value,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_read_value,
    input  logic [1:0]  i_status,
    input  logic [4:0]  i_count,
    input  logic [4:0]  i_capacity_now,
    input  logic        i_empty_res,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import ile_pkg::*;

    // Shadow copy of the list and its reported capacity.
    logic [31:0] list_words [DEPTH];
    logic [4:0]  list_count;
    logic [4:0]  list_cap;

    // Predicted result beats, oldest first.
    t_result expected_results [$];
    int      result_index;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        result_index = 0;
        list_count   = '0;
        list_cap     = '0;
    end

    // Print one line for a mismatch and count it.
    task automatic note_mismatch(input string field, input logic [31:0] seen,
                                 input logic [31:0] wanted);
        $display("%0t: mismatch in %s on result %0d: got 0x%0h, expected 0x%0h",
                 $time, field, result_index, seen, wanted);
        o_fail_count++;
    endtask

    // Make room for one more entry, growing the capacity when it is used up.
    // Returns 0 when the list already holds DEPTH entries.
    function automatic bit claim_slot();
        logic [5:0] doubled;
        if (list_count >= DEPTH) begin
            return 1'b0;
        end
        if (list_count >= list_cap) begin
            if (list_cap == '0) begin
                list_cap = 5'd1;
            end else begin
                doubled  = {list_cap, 1'b0};
                list_cap = (doubled > DEPTH) ? 5'(DEPTH) : doubled[4:0];
            end
        end
        return 1'b1;
    endfunction

    // Apply one action to the shadow list and return the beat it should give.
    function automatic t_result apply_list_action(input t_action act,
                                                  input logic [4:0] pos,
                                                  input logic [31:0] val);
        t_result r;
        int      i;
        r = '0;
        r.status = ST_OK;
        case (act)
            ACT_APPEND: begin
                if (!claim_slot()) begin
                    r.status = ST_FULL;
                end else begin
                    list_words[list_count[ADDR_W-1:0]] = val;
                    list_count++;
                end
            end
            ACT_INSERT: begin
                // The position check wins over the full check.
                if (pos > list_count) begin
                    r.status = ST_RANGE;
                end else if (!claim_slot()) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = int'(list_count); i > int'(pos); i--) begin
                        list_words[ADDR_W'(i)] = list_words[ADDR_W'(i-1)];
                    end
                    list_words[pos[ADDR_W-1:0]] = val;
                    list_count++;
                end
            end
            ACT_ERASE: begin
                if (pos >= list_count) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = int'(pos); i + 1 < int'(list_count); i++) begin
                        list_words[ADDR_W'(i)] = list_words[ADDR_W'(i+1)];
                    end
                    list_count--;
                end
            end
            default: begin
                if (pos >= list_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.read_value = list_words[pos[ADDR_W-1:0]];
                end
            end
        endcase
        r.count    = list_count;
        r.capacity = list_cap;
        r.empty    = (list_count == '0);
        return r;
    endfunction

    // Sample all channels at the clock edge, before the block updates them.
    always @(posedge i_clk) begin
        t_result wanted;
        if (!i_rst_n) begin
            list_count = '0;
            list_cap   = '0;
            expected_results.delete();
        end else begin
            // Result beat: compare against the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    note_mismatch("beat with nothing outstanding", i_read_value, '0);
                end else begin
                    wanted = expected_results.pop_front();
                    if (i_read_value !== wanted.read_value)
                        note_mismatch("read_value", i_read_value, wanted.read_value);
                    if (i_status !== wanted.status)
                        note_mismatch("status", 32'(i_status), 32'(wanted.status));
                    if (i_count !== wanted.count)
                        note_mismatch("count", 32'(i_count), 32'(wanted.count));
                    if (i_capacity_now !== wanted.capacity)
                        note_mismatch("capacity_now", 32'(i_capacity_now),
                                      32'(wanted.capacity));
                    if (i_empty_res !== wanted.empty)
                        note_mismatch("empty_res", 32'(i_empty_res), 32'(wanted.empty));
                end
                result_index++;
            end

            // Configuration write rebuilds the list with a new capacity.
            if (i_cfg_valid && i_cfg_ready) begin
                list_cap   = (i_cfg_data > DEPTH) ? 5'(DEPTH) : i_cfg_data;
                list_count = '0;
            end

            // Input beat: predict its result and queue it behind the others.
            if (i_in_valid && !i_in_stall) begin
                wanted = apply_list_action(t_action'(i_action), i_position,
                                           i_element_value);
                expected_results.insert(expected_results.size(), wanted);
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

/* sim/tb_indexed_list_engine.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_list_engine: testbench for the indexed list engine
// Drives a directed opening and then random list traffic under several
// capacity settings, with random idling on both sides and a long output
// hold-off. The checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_indexed_list_engine;
    import ile_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_action = '0;
    logic [4:0]  i_position = '0;
    logic [31:0] i_element_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_read_value;
    logic [1:0]  o_status;
    logic [4:0]  o_count;
    logic [4:0]  o_capacity_now;
    logic        o_empty_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = '0;

    int fail_count;
    int pending;

    // Idle chances in percent, and the long hold-off request.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // Number of entries the list should hold, used to aim positions.
    int level = 0;

    always #6 i_clk = ~i_clk;

    indexed_list_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_position      (i_position),
        .i_element_value (i_element_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_read_value    (o_read_value),
        .o_status        (o_status),
        .o_count         (o_count),
        .o_capacity_now  (o_capacity_now),
        .o_empty_res     (o_empty_res),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    ile_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_action        (i_action),
        .i_position      (i_position),
        .i_element_value (i_element_value),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_read_value    (o_read_value),
        .i_status        (o_status),
        .i_count         (o_count),
        .i_capacity_now  (o_capacity_now),
        .i_empty_res     (o_empty_res),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Result side: a requested hold-off stalls for a long stretch,
    // otherwise stall at random.
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 64;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Offer one input beat, idling first at random, and wait until it is taken.
    task automatic send_beat(input t_action act, input logic [4:0] pos,
                             input logic [31:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_action        <= act;
        i_position      <= pos;
        i_element_value <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        case (act)
            ACT_APPEND: if (level < DEPTH) level++;
            ACT_INSERT: if (int'(pos) <= level && level < DEPTH) level++;
            ACT_ERASE:  if (int'(pos) < level) level--;
            default:    ;
        endcase
    endtask

    // Let the block drain, then write the capacity register.
    task automatic set_capacity(input logic [4:0] cap);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        level = 0;
    endtask

    // Generous overall limit.
    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int          blk;
        int          n;
        int          roll;
        int          trend;
        t_action     act;
        logic [4:0]  pos;
        logic [31:0] val;
        logic [4:0]  cap;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 34;
        recv_idle_pct <= 45;

        // Directed opening with the capacity at its reset value of zero.
        send_beat(ACT_READ,   5'd0,  32'h0);
        send_beat(ACT_ERASE,  5'd0,  32'h0);
        send_beat(ACT_INSERT, 5'd1,  32'h1234_5678);
        send_beat(ACT_INSERT, 5'd31, 32'hFFFF_FFFF);
        send_beat(ACT_APPEND, 5'd31, 32'hFFFF_FFFF);
        send_beat(ACT_APPEND, 5'd0,  32'h0000_0000);
        send_beat(ACT_INSERT, 5'd0,  32'hA5A5_A5A5);
        send_beat(ACT_INSERT, 5'd3,  32'h5A5A_5A5A);
        send_beat(ACT_READ,   5'd0,  32'h0);
        send_beat(ACT_READ,   5'd1,  32'h0);
        send_beat(ACT_READ,   5'd2,  32'h0);
        send_beat(ACT_READ,   5'd3,  32'h0);
        send_beat(ACT_READ,   5'd4,  32'h0);
        send_beat(ACT_ERASE,  5'd1,  32'h0);
        send_beat(ACT_ERASE,  5'd2,  32'h0);
        send_beat(ACT_ERASE,  5'd0,  32'h0);
        send_beat(ACT_READ,   5'd0,  32'h0);
        send_beat(ACT_ERASE,  5'd0,  32'h0);
        send_beat(ACT_READ,   5'd16, 32'h0);

        // Random blocks, each under its own capacity setting.
        for (blk = 0; blk < 6; blk++) begin
            case (blk)
                0:       cap = 5'd16;
                1:       cap = 5'd1;
                2:       cap = 5'd31;
                3:       cap = 5'd0;
                4:       cap = 5'd3;
                default: cap = 5'd5;
            endcase
            set_capacity(cap);
            case (blk / 2)
                0: begin
                    send_idle_pct = 34;
                    recv_idle_pct <= 45;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_idle_pct <= 34;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            trend = 0;
            for (n = 0; n < 150; n++) begin
                // Long output hold-off while the sender keeps offering.
                if (n == 40 && (blk % 2) == 0) hold_req <= hold_req + 1;
                if (n >= 20 && (n % 30) == 0) trend = $urandom_range(0, 2);

                // Action: the first twenty beats only append or insert, to fill the list.
                roll = $urandom_range(0, 99);
                if (n < 20) begin
                    act = (roll < 50) ? ACT_APPEND : ACT_INSERT;
                end else if (trend == 0) begin
                    act = (roll < 35) ? ACT_APPEND : (roll < 70) ? ACT_INSERT :
                          (roll < 80) ? ACT_ERASE : ACT_READ;
                end else if (trend == 1) begin
                    act = (roll < 8) ? ACT_APPEND : (roll < 15) ? ACT_INSERT :
                          (roll < 70) ? ACT_ERASE : ACT_READ;
                end else begin
                    act = t_action'(roll % 4);
                end

                // Position: mostly valid for the current fill, some out of range.
                roll = $urandom_range(0, 99);
                if (act == ACT_APPEND || roll < 6) begin
                    pos = 5'($urandom_range(0, 31));
                end else if (roll < 20) begin
                    pos = 5'($urandom_range(0, 16));
                end else if (act == ACT_INSERT) begin
                    pos = 5'($urandom_range(0, level));
                end else begin
                    pos = (level == 0) ? 5'd0 : 5'($urandom_range(0, level - 1));
                end

                roll = $urandom_range(0, 99);
                val = (roll < 8) ? 32'h0 : (roll < 16) ? 32'hFFFF_FFFF : $urandom;
                send_beat(act, pos, val);
            end
        end

        // Drain and give the verdict.
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
